// ===== design/slr_pkg.sv =====
// Package with shared constants of the shaded line rasterizer.
`default_nettype none
package slr_pkg;
    localparam int COORD_BITS_DEF    = 12;
    localparam int CHANNEL_BITS_DEF  = 8;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int NUM_CHANNELS      = 4;
    localparam int QUEUE_DEPTH       = 2;

    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_STEP  = 1'b1;
endpackage
`default_nettype wire

// ===== design/slr_if.sv =====
// Valid/ready channel interfaces for requests and pixels.
`default_nettype none
interface slr_in_if #(
    parameter int COORD_BITS   = 12,
    parameter int CHANNEL_BITS = 8
);
    logic                      valid;
    logic                      ready;
    logic                      func;
    logic [COORD_BITS-1:0]     x_start;
    logic [COORD_BITS-1:0]     y_start;
    logic [4*CHANNEL_BITS-1:0] color_start;
    logic [COORD_BITS-1:0]     x_end;
    logic [COORD_BITS-1:0]     y_end;
    logic [4*CHANNEL_BITS-1:0] color_end;
    modport source (output valid, func, x_start, y_start, color_start, x_end, y_end,
                    color_end, input ready);
    modport sink (input valid, func, x_start, y_start, color_start, x_end, y_end,
                  color_end, output ready);
endinterface

interface slr_out_if #(
    parameter int COORD_BITS   = 12,
    parameter int CHANNEL_BITS = 8
);
    logic                      valid;
    logic                      ready;
    logic [COORD_BITS-1:0]     pixel_x;
    logic [COORD_BITS-1:0]     pixel_y;
    logic [4*CHANNEL_BITS-1:0] pixel_color;
    logic                      last;
    modport source (output valid, pixel_x, pixel_y, pixel_color, last, input ready);
    modport sink (input valid, pixel_x, pixel_y, pixel_color, last, output ready);
endinterface
`default_nettype wire

// ===== design/slr_front.sv =====
// Front end: accepts requests, drops steps while no line runs, and queues the rest.
`default_nettype none
module slr_front #(
    parameter int COORD_BITS   = 12,
    parameter int CHANNEL_BITS = 8
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    slr_in_if.sink                         i_req,
    input  wire logic                      i_line_live,
    input  wire logic                      i_q_pop,
    output logic                           o_q_valid,
    output logic                           o_q_func,
    output logic [COORD_BITS-1:0]          o_q_xs,
    output logic [COORD_BITS-1:0]          o_q_ys,
    output logic [4*CHANNEL_BITS-1:0]      o_q_cs,
    output logic [COORD_BITS-1:0]          o_q_xe,
    output logic [COORD_BITS-1:0]          o_q_ye,
    output logic [4*CHANNEL_BITS-1:0]      o_q_ce
);
    import slr_pkg::*;

    localparam int EW = 1 + 4 * COORD_BITS + 8 * CHANNEL_BITS;
    typedef logic [EW-1:0] t_entry;

    t_entry r_mem [QUEUE_DEPTH];
    logic   r_wp, r_rp;
    logic [1:0] r_cnt;
    logic   push, pop;
    // Set while at least one start request waits in the queue.
    logic   r_pend_start;
    t_entry rd;

    // Checks whether the entry behind the head is also a start.
    function automatic logic rd_other_start();
        t_entry e;
        e = r_mem[~r_rp];
        return e[EW-1] == FUNC_START;
    endfunction

    assign i_req.ready = (r_cnt != 2'(QUEUE_DEPTH));
    // A step with no line live or queued is consumed and discarded.
    assign push = i_req.valid && i_req.ready &&
                  ((i_req.func == FUNC_START) || i_line_live || r_pend_start);
    assign pop  = i_q_pop && o_q_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= '0;
            r_pend_start <= 1'b0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
            if (push && i_req.func == FUNC_START) r_pend_start <= 1'b1;
            else if (pop && o_q_func == FUNC_START &&
                     !(r_cnt == 2'd2 && rd_other_start())) r_pend_start <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push)
            r_mem[r_wp] <= {i_req.func, i_req.x_start, i_req.y_start, i_req.color_start,
                            i_req.x_end, i_req.y_end, i_req.color_end};
    end

    assign rd = r_mem[r_rp];
    assign o_q_valid = (r_cnt != 2'd0);
    assign {o_q_func, o_q_xs, o_q_ys, o_q_cs, o_q_xe, o_q_ye, o_q_ce} = rd;
endmodule
`default_nettype wire

// ===== design/slr_div.sv =====
// Signed restoring divider for the color slopes, one quotient bit per cycle.
`default_nettype none
module slr_div #(
    parameter int NW = 25,
    parameter int DW = 12
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_go,
    input  wire logic signed [NW-1:0] i_num,
    input  wire logic [DW-1:0]        i_den,
    output logic                      o_busy,
    output logic signed [NW-1:0]      o_quo
);
    localparam int CW = $clog2(NW + 1);
    logic [NW-1:0] r_q;
    logic [DW:0]   r_rem;
    logic [DW-1:0] r_den;
    logic          r_neg;
    logic [CW-1:0] r_cnt;
    logic [DW:0]   trial;
    logic [DW:0]   sh;

    assign sh    = {r_rem[DW-1:0], r_q[NW-1]};
    assign trial = sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_go) begin
            r_cnt <= CW'(NW);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // Magnitude divide; sign restored on the output.
    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_q   <= i_num[NW-1] ? NW'(-i_num) : i_num;
            r_neg <= i_num[NW-1];
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_cnt != '0) begin
            if (!trial[DW]) begin
                r_rem <= trial;
                r_q   <= {r_q[NW-2:0], 1'b1};
            end else begin
                r_rem <= sh;
                r_q   <= {r_q[NW-2:0], 1'b0};
            end
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quo  = r_neg ? -$signed(r_q) : $signed(r_q);
endmodule
`default_nettype wire

// ===== design/slr_back.sv =====
// Back end: line setup with slope divides, then one pixel per step request on an active line.
`default_nettype none
module slr_back #(
    parameter int COORD_BITS    = 12,
    parameter int CHANNEL_BITS  = 8,
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_q_valid,
    input  wire logic                     i_q_func,
    input  wire logic [COORD_BITS-1:0]    i_q_xs,
    input  wire logic [COORD_BITS-1:0]    i_q_ys,
    input  wire logic [4*CHANNEL_BITS-1:0] i_q_cs,
    input  wire logic [COORD_BITS-1:0]    i_q_xe,
    input  wire logic [COORD_BITS-1:0]    i_q_ye,
    input  wire logic [4*CHANNEL_BITS-1:0] i_q_ce,
    output logic                          o_q_pop,
    output logic                          o_line_live,
    slr_out_if.source                     o_pix
);
    import slr_pkg::*;

    localparam int AW = CHANNEL_BITS + FRACTION_BITS + 2;
    localparam int EW = COORD_BITS + 3;
    localparam int CIW = $clog2(NUM_CHANNELS);
    localparam logic [1:0] ST_RUN  = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;

    logic [1:0] r_state;
    logic [CIW-1:0] r_ch;
    logic r_active, r_steep, r_mjdir, r_mndir;
    logic [COORD_BITS-1:0] r_mj, r_mn, r_stop, r_dmj, r_dmn;
    logic signed [EW-1:0] r_err;
    logic signed [AW-1:0] r_acc [NUM_CHANNELS];
    logic signed [AW-1:0] r_stp [NUM_CHANNELS];
    logic [4*CHANNEL_BITS-1:0] r_cs, r_ce;

    logic r_ov;
    logic [COORD_BITS-1:0] r_px, r_py;
    logic [4*CHANNEL_BITS-1:0] r_pc;
    logic r_pl;

    logic signed [COORD_BITS:0] dx, dy;
    logic [COORD_BITS-1:0] adx, ady;
    logic steep_n;
    logic out_free, do_step, do_start;
    logic div_go, div_busy;
    logic signed [AW-1:0] div_num, div_quo;
    logic signed [EW-1:0] t_err;
    logic [COORD_BITS-1:0] mj_n, mn_n;
    logic signed [AW-1:0] acc_n [NUM_CHANNELS];
    logic [4*CHANNEL_BITS-1:0] col_n;

    assign dx = $signed({1'b0, i_q_xe}) - $signed({1'b0, i_q_xs});
    assign dy = $signed({1'b0, i_q_ye}) - $signed({1'b0, i_q_ys});
    assign adx = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
    assign ady = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
    assign steep_n = ady > adx;

    assign out_free = !r_ov || o_pix.ready;
    assign do_start = r_state == ST_RUN && i_q_valid && i_q_func == FUNC_START;
    assign do_step  = r_state == ST_RUN && i_q_valid && i_q_func == FUNC_STEP && out_free;
    assign o_q_pop  = do_start || (do_step);
    assign o_line_live = r_active || r_state != ST_RUN;

    // Slope numerator for the channel being divided.
    always_comb begin
        logic [CHANNEL_BITS-1:0] a, b;
        a = r_cs[(NUM_CHANNELS-1-32'(r_ch))*CHANNEL_BITS +: CHANNEL_BITS];
        b = r_ce[(NUM_CHANNELS-1-32'(r_ch))*CHANNEL_BITS +: CHANNEL_BITS];
        div_num = ($signed({2'b0, b}) - $signed({2'b0, a})) <<< FRACTION_BITS;
    end
    assign div_go = r_state == ST_DIV;

    slr_div #(.NW(AW), .DW(COORD_BITS)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_go(div_go), .i_num(div_num),
        .i_den(r_dmj), .o_busy(div_busy), .o_quo(div_quo)
    );

    // Bresenham and color datapath for one step.
    always_comb begin
        t_err = r_err + $signed({2'b0, r_dmn, 1'b0});
        mj_n  = r_mjdir ? r_mj - 1'b1 : r_mj + 1'b1;
        mn_n  = r_mn;
        if (t_err > $signed({3'b0, r_dmj}))
            mn_n = r_mndir ? r_mn - 1'b1 : r_mn + 1'b1;
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            acc_n[i] = r_acc[i] + r_stp[i];
            if (acc_n[i] < 0)
                col_n[(NUM_CHANNELS-1-i)*CHANNEL_BITS +: CHANNEL_BITS] = '0;
            else if (acc_n[i][AW-2:FRACTION_BITS+CHANNEL_BITS] != '0)
                col_n[(NUM_CHANNELS-1-i)*CHANNEL_BITS +: CHANNEL_BITS] = '1;
            else
                col_n[(NUM_CHANNELS-1-i)*CHANNEL_BITS +: CHANNEL_BITS] =
                    acc_n[i][FRACTION_BITS +: CHANNEL_BITS];
        end
    end

    // Control sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_RUN;
            r_active <= 1'b0;
            r_ch     <= '0;
            r_ov     <= 1'b0;
        end else begin
            if (do_step && r_active) r_ov <= 1'b1;
            else if (o_pix.ready) r_ov <= 1'b0;
            unique case (r_state)
                ST_RUN: begin
                    if (do_start) begin
                        r_active <= 1'b0;
                        r_ch     <= '0;
                        if (adx != '0 || ady != '0) r_state <= ST_DIV;
                    end else if (do_step && r_active) begin
                        if (mj_n == r_stop) r_active <= 1'b0;
                    end
                end
                ST_DIV:  r_state <= ST_WAIT;
                ST_WAIT: begin
                    if (!div_busy) begin
                        r_ch <= r_ch + 1'b1;
                        if (r_ch == CIW'(NUM_CHANNELS-1)) begin
                            r_state  <= ST_RUN;
                            r_active <= 1'b1;
                        end else begin
                            r_state <= ST_DIV;
                        end
                    end
                end
                default: r_state <= ST_RUN;
            endcase
        end
    end

    // Line data and output register.
    always_ff @(posedge i_clk) begin
        if (do_start) begin
            r_steep <= steep_n;
            r_mj    <= steep_n ? i_q_ys : i_q_xs;
            r_stop  <= steep_n ? i_q_ye : i_q_xe;
            r_mn    <= steep_n ? i_q_xs : i_q_ys;
            r_mjdir <= steep_n ? dy[COORD_BITS] : dx[COORD_BITS];
            r_mndir <= steep_n ? dx[COORD_BITS] : dy[COORD_BITS];
            r_dmj   <= steep_n ? ady : adx;
            r_dmn   <= steep_n ? adx : ady;
            r_err   <= '0;
            r_cs    <= i_q_cs;
            r_ce    <= i_q_ce;
            for (int i = 0; i < NUM_CHANNELS; i++)
                r_acc[i] <= AW'({i_q_cs[(NUM_CHANNELS-1-i)*CHANNEL_BITS +: CHANNEL_BITS],
                                 FRACTION_BITS'(0)});
        end
        if (r_state == ST_WAIT && !div_busy)
            r_stp[r_ch] <= div_quo;
        if (do_step && r_active) begin
            r_mj  <= mj_n;
            r_mn  <= mn_n;
            r_err <= (t_err > $signed({3'b0, r_dmj})) ?
                     t_err - $signed({2'b0, r_dmj, 1'b0}) : t_err;
            for (int i = 0; i < NUM_CHANNELS; i++) r_acc[i] <= acc_n[i];
            r_px <= r_steep ? mn_n : mj_n;
            r_py <= r_steep ? mj_n : mn_n;
            r_pc <= col_n;
            r_pl <= mj_n == r_stop;
        end
    end

    assign o_pix.valid       = r_ov;
    assign o_pix.pixel_x     = r_px;
    assign o_pix.pixel_y     = r_py;
    assign o_pix.pixel_color = r_pc;
    assign o_pix.last        = r_pl;
endmodule
`default_nettype wire

// ===== design/shaded_line_rasterizer_top.sv =====
// Top level of the shaded line rasterizer.
//  channel  | dir | payload
//  i_req    | in  | func, x_start, y_start, color_start, x_end, y_end, color_end
//  o_pix    | out | pixel_x, pixel_y, pixel_color, last
// A step request on an active line yields one pixel per cycle, while o_pix is not
// stalled, from a registered output stage. A start request of nonzero length runs the
// shared one-bit-per-cycle slope divider once per color channel.
// Reset is synchronous, active low, and clears the queue and the line state.
// A two-entry request queue lets requests arrive while the back end divides or stalls.
`default_nettype none
module shaded_line_rasterizer_top #(
    parameter int COORD_BITS    = slr_pkg::COORD_BITS_DEF,
    parameter int CHANNEL_BITS  = slr_pkg::CHANNEL_BITS_DEF,
    parameter int FRACTION_BITS = slr_pkg::FRACTION_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    slr_in_if.sink    i_req,
    slr_out_if.source o_pix
);
    logic q_valid, q_func, q_pop, line_live;
    logic [COORD_BITS-1:0] q_xs, q_ys, q_xe, q_ye;
    logic [4*CHANNEL_BITS-1:0] q_cs, q_ce;

    slr_front #(.COORD_BITS(COORD_BITS), .CHANNEL_BITS(CHANNEL_BITS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(i_req), .i_line_live(line_live),
        .i_q_pop(q_pop), .o_q_valid(q_valid), .o_q_func(q_func), .o_q_xs(q_xs),
        .o_q_ys(q_ys), .o_q_cs(q_cs), .o_q_xe(q_xe), .o_q_ye(q_ye), .o_q_ce(q_ce)
    );

    slr_back #(.COORD_BITS(COORD_BITS), .CHANNEL_BITS(CHANNEL_BITS),
               .FRACTION_BITS(FRACTION_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_q_valid(q_valid), .i_q_func(q_func),
        .i_q_xs(q_xs), .i_q_ys(q_ys), .i_q_cs(q_cs), .i_q_xe(q_xe), .i_q_ye(q_ye),
        .i_q_ce(q_ce), .o_q_pop(q_pop), .o_line_live(line_live), .o_pix(o_pix)
    );
endmodule
`default_nettype wire

// ===== sim/shaded_line_rasterizer_top_tb.sv =====
// Self-checking testbench of the shaded line rasterizer: directed and random lines.
`default_nettype none
module shaded_line_rasterizer_top_tb;
    import slr_pkg::*;

    localparam int CB = 12;
    localparam int HB = 8;
    localparam int FB = 16;
    localparam int NRAND = 1850;
    localparam longint CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic          func;
        logic [CB-1:0] xs;
        logic [CB-1:0] ys;
        logic [31:0]   cs;
        logic [CB-1:0] xe;
        logic [CB-1:0] ye;
        logic [31:0]   ce;
    } line_req_t;

    typedef struct packed {
        logic [CB-1:0] px;
        logic [CB-1:0] py;
        logic [31:0]   color;
        logic          last;
    } pixel_t;

    // A directed row: the request plus an optional hand-typed pixel.
    typedef struct packed {
        line_req_t req;
        logic      has_pix;
        pixel_t    pix;
    } dir_row_t;

    logic i_clk = 1'b0;
    logic i_rst_n;
    slr_in_if  #(.COORD_BITS(CB), .CHANNEL_BITS(HB)) req_if ();
    slr_out_if #(.COORD_BITS(CB), .CHANNEL_BITS(HB)) pix_if ();

    shaded_line_rasterizer_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_pix   (pix_if)
    );

    // Clock generation.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Line walker state, mirrors the block.
    logic              ln_active;
    logic              ln_steep;
    logic [CB-1:0]     ln_major, ln_minor, ln_stop;
    logic              ln_major_dn, ln_minor_dn;
    int                ln_dmaj, ln_dmin, ln_err;
    longint            ln_acc[4];
    longint            ln_slope[4];

    pixel_t expected_pixels[$];
    int     errors = 0;
    longint cycles = 0;

    function automatic logic [HB-1:0] clamp_channel(longint acc);
        longint v;
        if (acc < 0) return '0;
        v = acc >>> FB;
        if (v > 255) v = 255;
        return v[HB-1:0];
    endfunction

    // Advance the line walker by one request and queue any pixel it yields.
    task automatic walk_line(input line_req_t r);
        int dx, dy, adx, ady, t;
        longint a, b;
        pixel_t p;
        if (r.func == FUNC_START) begin
            dx = int'(r.xe) - int'(r.xs);
            dy = int'(r.ye) - int'(r.ys);
            adx = dx < 0 ? -dx : dx;
            ady = dy < 0 ? -dy : dy;
            ln_steep = ady > adx;
            if (ln_steep) begin
                ln_major = r.ys; ln_stop = r.ye; ln_minor = r.xs;
                ln_major_dn = dy < 0; ln_minor_dn = dx < 0;
                ln_dmaj = ady; ln_dmin = adx;
            end else begin
                ln_major = r.xs; ln_stop = r.xe; ln_minor = r.ys;
                ln_major_dn = dx < 0; ln_minor_dn = dy < 0;
                ln_dmaj = adx; ln_dmin = ady;
            end
            ln_err = 0;
            for (int i = 0; i < 4; i++) begin
                a = longint'(r.cs[(3-i)*HB +: HB]);
                b = longint'(r.ce[(3-i)*HB +: HB]);
                ln_acc[i] = a <<< FB;
                ln_slope[i] = ln_dmaj != 0 ? ((b - a) <<< FB) / ln_dmaj : 0;
            end
            ln_active = ln_dmaj != 0;
        end else if (ln_active) begin
            t = ln_err + 2 * ln_dmin;
            ln_major = ln_major_dn ? ln_major - 1'b1 : ln_major + 1'b1;
            if (t > ln_dmaj) begin
                ln_minor = ln_minor_dn ? ln_minor - 1'b1 : ln_minor + 1'b1;
                ln_err = t - 2 * ln_dmaj;
            end else begin
                ln_err = t;
            end
            for (int i = 0; i < 4; i++) begin
                ln_acc[i] += ln_slope[i];
                p.color[(3-i)*HB +: HB] = clamp_channel(ln_acc[i]);
            end
            p.px = ln_steep ? ln_minor : ln_major;
            p.py = ln_steep ? ln_major : ln_minor;
            p.last = ln_major == ln_stop;
            if (p.last) ln_active = 1'b0;
            expected_pixels.push_back(p);
        end
    endtask

    // Random gap: none half the time, otherwise mostly short and sometimes long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Send one request and update the predictor on acceptance.
    // Valid stays high between back-to-back requests and drops only for a gap.
    task automatic send_request(input line_req_t r);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid       <= 1'b1;
        req_if.func        <= r.func;
        req_if.x_start     <= r.xs;
        req_if.y_start     <= r.ys;
        req_if.color_start <= r.cs;
        req_if.x_end       <= r.xe;
        req_if.y_end       <= r.ye;
        req_if.color_end   <= r.ce;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        walk_line(r);
    endtask

    // Stop sending and wait until every expected pixel has come out.
    task automatic drain();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_pixels.size() != 0) @(posedge i_clk);
    endtask

    function automatic line_req_t make_start(int span);
        line_req_t r;
        r.func = FUNC_START;
        r.xs = CB'($urandom); r.ys = CB'($urandom);
        r.cs = $urandom; r.ce = $urandom;
        r.xe = CB'(int'(r.xs) + int'($urandom_range(0, 2 * span)) - span);
        r.ye = CB'(int'(r.ys) + int'($urandom_range(0, 2 * span)) - span);
        return r;
    endfunction

    function automatic line_req_t make_step();
        line_req_t r;
        r.func = FUNC_STEP;
        r.xs = CB'($urandom); r.ys = CB'($urandom);
        r.cs = $urandom; r.ce = $urandom;
        r.xe = CB'($urandom); r.ye = CB'($urandom);
        return r;
    endfunction

    // Output side: random stalls, compare each pixel with the oldest expectation.
    always @(posedge i_clk) begin
        pixel_t e;
        if (!i_rst_n) begin
            pix_if.ready <= 1'b0;
        end else begin
            if (pix_if.valid && pix_if.ready) begin
                if (expected_pixels.size() == 0) begin
                    $error("unexpected pixel x=%0d y=%0d", pix_if.pixel_x, pix_if.pixel_y);
                    errors++;
                end else begin
                    e = expected_pixels.pop_front();
                    if (pix_if.pixel_x !== e.px) begin
                        $error("pixel_x expected %0d got %0d", e.px, pix_if.pixel_x);
                        errors++;
                    end
                    if (pix_if.pixel_y !== e.py) begin
                        $error("pixel_y expected %0d got %0d", e.py, pix_if.pixel_y);
                        errors++;
                    end
                    if (pix_if.pixel_color !== e.color) begin
                        $error("pixel_color expected %h got %h", e.color,
                               pix_if.pixel_color);
                        errors++;
                    end
                    if (pix_if.last !== e.last) begin
                        $error("last expected %b got %b", e.last, pix_if.last);
                        errors++;
                    end
                end
            end
            pix_if.ready <= ($urandom_range(0, 99) < 96) ? ($urandom_range(0, 3) != 0)
                                                         : 1'b0;
        end
    end

    // Cycle limit.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    dir_row_t dir_rows[$];

    task automatic add_row(input line_req_t r, input logic hp, input pixel_t p);
        dir_row_t d;
        d.req = r; d.has_pix = hp; d.pix = p;
        dir_rows.push_back(d);
    endtask

    function automatic line_req_t req_of(logic f, int xs, int ys, logic [31:0] cs,
                                         int xe, int ye, logic [31:0] ce);
        line_req_t r;
        r.func = f; r.xs = CB'(xs); r.ys = CB'(ys); r.cs = cs;
        r.xe = CB'(xe); r.ye = CB'(ye); r.ce = ce;
        return r;
    endfunction

    initial begin
        line_req_t r;
        pixel_t    np;
        int        left, len;
        ln_active = 1'b0; ln_steep = 1'b0;
        ln_major = '0; ln_minor = '0; ln_stop = '0;
        ln_major_dn = 1'b0; ln_minor_dn = 1'b0;
        ln_dmaj = 0; ln_dmin = 0; ln_err = 0;
        for (int i = 0; i < 4; i++) begin
            ln_acc[i] = 0; ln_slope[i] = 0;
        end
        np = '0;
        i_rst_n = 1'b0;
        req_if.valid = 1'b0;
        req_if.func = FUNC_STEP;
        req_if.x_start = '0; req_if.y_start = '0; req_if.color_start = '0;
        req_if.x_end = '0; req_if.y_end = '0; req_if.color_end = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table.
        // Step after reset while idle: no pixel.
        add_row(req_of(FUNC_STEP, 4095, 4095, '1, 4095, 4095, '1), 1'b0, np);
        // Zero-length line, then a step that must stay silent.
        add_row(req_of(FUNC_START, 7, 9, 32'h11223344, 7, 9, 32'h55667788), 1'b0, np);
        add_row(req_of(FUNC_STEP, 0, 0, '0, 0, 0, '0), 1'b0, np);
        // One-pixel line from 0,0 to 1,0 reaches the end color exactly.
        add_row(req_of(FUNC_START, 0, 0, 32'h00000000, 1, 0, 32'hFF00FF80), 1'b0, np);
        add_row(req_of(FUNC_STEP, 0, 0, '0, 0, 0, '0), 1'b1,
                '{px: 1, py: 0, color: 32'hFF00FF80, last: 1'b1});
        // Full-range diagonal descending, steep tie goes to x.
        add_row(req_of(FUNC_START, 4095, 4095, '1, 0, 0, '0), 1'b0, np);
        add_row(req_of(FUNC_STEP, 0, 0, '0, 0, 0, '0), 1'b0, np);
        add_row(req_of(FUNC_STEP, 0, 0, '0, 0, 0, '0), 1'b0, np);
        // Start while active drops the running line; steep line, halfway cases.
        add_row(req_of(FUNC_START, 10, 10, 32'h00FF00FF, 11, 14, 32'hFF00FF00), 1'b0, np);
        for (int i = 0; i < 4; i++)
            add_row(req_of(FUNC_STEP, 0, 0, '0, 0, 0, '0), 1'b0, np);
        // Shallow line with halfway points, going left and up.
        add_row(req_of(FUNC_START, 20, 20, 32'h80808080, 16, 18, 32'h00FF7F01), 1'b0, np);
        for (int i = 0; i < 5; i++)
            add_row(req_of(FUNC_STEP, 0, 0, '0, 0, 0, '0), 1'b0, np);
        // Single diagonal pixel at the far edge: 4095 to 4094, the tie goes to x.
        add_row(req_of(FUNC_START, 4095, 1, 32'hFFFFFFFF, 4094, 0, 32'h0), 1'b0, np);
        add_row(req_of(FUNC_STEP, 0, 0, '0, 0, 0, '0), 1'b1,
                '{px: 4094, py: 0, color: 32'h00000000, last: 1'b1});

        foreach (dir_rows[k]) begin
            send_request(dir_rows[k].req);
            if (dir_rows[k].has_pix) begin
                if (expected_pixels.size() == 0 ||
                    expected_pixels[$] !== dir_rows[k].pix) begin
                    $error("directed row %0d pixel expected %h got %h", k,
                           dir_rows[k].pix, expected_pixels[$]);
                    errors++;
                end
            end
        end
        drain();

        // Random part: mostly well-formed lines with short spans, a few long ones.
        left = NRAND;
        while (left > 0) begin
            r = make_start(($urandom_range(0, 19) == 0) ? 4095 : $urandom_range(0, 12));
            if ($urandom_range(0, 29) == 0) begin
                r.xe = r.xs; r.ye = r.ys;
            end
            send_request(r);
            left--;
            len = $urandom_range(0, 99) < 85 ? 30 : $urandom_range(0, 8);
            if ($urandom_range(0, 49) == 0) len = 200;
            for (int s = 0; s < len && left > 0; s++) begin
                if (!ln_active && $urandom_range(0, 3) != 0) break;
                send_request(make_step());
                left--;
            end
            // Hold off now and then until the block has drained.
            if ($urandom_range(0, 24) == 0)
                drain();
        end

        drain();
        repeat (200) @(posedge i_clk);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== shaded_line_rasterizer_top.f =====
design/slr_pkg.sv
design/slr_if.sv
design/slr_front.sv
design/slr_div.sv
design/slr_back.sv
design/shaded_line_rasterizer_top.sv
sim/shaded_line_rasterizer_top_tb.sv
